>>> rtl/hjs_pkg.sv
// Shared types and constants of the five-point Jacobi heat stencil.
// No dependencies.
package hjs_pkg;

  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int REG_SEL_BIT = 2;

  localparam int GW_BITS = 11;
  localparam int GH_BITS = 16;
  localparam int GW_RESET = 90;
  localparam int GH_RESET = 90;
  localparam int MIN_DIM = 3;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item control captured with the stencil operands.
  typedef struct packed {
    logic has_above;
    logic interior;
    logic last_row;
    logic last_col;
  } item_flags_t;

endpackage

>>> rtl/hjs_out_fifo.sv
// Four-entry result queue that takes one or two entries per cycle.
// Depends on nothing; instantiated by the stencil top level.
module hjs_out_fifo #(
  parameter int DW = 65
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          push_two_i,
  input  logic [DW-1:0] data0_i,
  input  logic [DW-1:0] data1_i,
  output logic          room2_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_next;
  logic [PW:0]   count_q, count_d, push_n;
  logic          pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room2_o = (count_q <= (PW+1)'(DEPTH - 2));
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_ptr_q + PW'(1);

  always_comb begin
    push_n = '0;
    if (push_i) begin
      push_n = push_two_i ? (PW+1)'(2) : (PW+1)'(1);
    end
    count_d = count_q + push_n - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data0_i;
      if (push_two_i) begin
        mem_q[wr_next] <= data1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[PW-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/heat_jacobi_stencil_2d_top.sv
// Top level of the streaming five-point Jacobi heat stencil (Q16.16 samples).
// Depends on hjs_pkg and hjs_out_fifo.
//
// Usage: old grid cells enter on the s_axis channel in raster order, one per
// transaction. The new field leaves on m_axis one row behind: nothing while
// row 0 arrives, one result per cell of rows 1 .. height-2 (the cell above),
// and two per cell of the last row (the cell above, then the border cell).
// Interior cells get c + floor((n+s+e+w-4c)/4), saturated; border cells pass.
// tdata carries the new value and the running max |du| of the grid; tuser
// flags the final result of an input; tlast flags the grid's final cell.
// The stencil stage registers each accepted input and pushes its results into
// the result queue once the queue has room; the queue registers them for m_axis.
// Throughput: one input per cycle while the result queue has room for two more;
// in the last row the output side moves two results per input, so input runs
// at half rate there.
// A stalled receiver backs results up until the queue cannot take two more;
// the stencil stage then holds and s_axis_tready drops; nothing is lost.
// Reset restores width and height to 90 and restarts the grid; line buffers
// are not cleared. Width/height are set over APB; the user must do so while
// idle, which the block does not enforce, and any such write restarts the grid.
module heat_jacobi_stencil_2d_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hjs_pkg::ADDR_BITS-1:0]           paddr,
  input  logic [hjs_pkg::DATA_BITS-1:0]           pwdata,
  output logic [hjs_pkg::DATA_BITS-1:0]           prdata,
  output logic                                    pready,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // cell_value, zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // new_value, residual, zero padding
  output logic [((2*SAMPLE_BITS-1+7)/8)*8-1:0]    m_axis_tdata,
  // grid_done
  output logic                                    m_axis_tlast,
  // last_of_item
  output logic                                    m_axis_tuser
);
  import hjs_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int RB   = SB - 1;
  localparam int EW   = SB + RB + 2;
  localparam int OTW  = ((2*SAMPLE_BITS-1+7)/8)*8;
  localparam int PADW = OTW - SB - RB;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > GW_BITS) ? WW : GW_BITS;
  localparam logic [CW-1:0] WLAST_RST =
    CW'(((GW_RESET > MAX_WIDTH) ? MAX_WIDTH : GW_RESET) - 1);
  localparam logic [GH_BITS-1:0] HLAST_RST = GH_BITS'(GH_RESET - 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  // configuration
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;
  logic [GW_BITS-1:0] gw_q;
  logic [GH_BITS-1:0] gh_q, hlast_q, hlast_new;
  logic [CW-1:0]      wlast_q, wlast_new;
  logic [CMPW-1:0]    gw_ext, wsel;

  // grid position and line buffers
  logic [CW-1:0]      col_q;
  logic [GH_BITS-1:0] row_q;
  logic               wrap_q;
  logic signed [SB-1:0] la_mem [MAX_WIDTH];
  logic signed [SB-1:0] lta_mem [MAX_WIDTH];
  logic signed [SB-1:0] la_rd_q, lta_rd_q;
  logic signed [SB-1:0] above_q, left_q, s0_q, s1_q, n0_q;
  logic signed [SB-1:0] cur, east_e, north_e;
  logic [CW:0]          la_raddr_w, lta_raddr_w;
  logic [CW-1:0]        la_raddr, lta_raddr;
  logic                 s_acc, last_col, last_row;
  item_flags_t          flags;

  // stencil stage
  logic                 a_valid_q;
  item_flags_t          a_flags_q;
  logic signed [SB-1:0] a_cur_q, a_above_q, a_north_q, a_left_q, a_east_q;
  logic                 b_go, room2;
  logic signed [SB+2:0] sum;
  logic signed [SB:0]   du;
  logic signed [SB+1:0] val;
  logic signed [SB-1:0] val_sat, r0_val;
  logic [SB:0]          mag;
  logic [RB-1:0]        mag_sat, max_q, max_new;
  logic [EW-1:0]        res0, res1, push_d0, push_d1, q_data;
  logic                 push, push_two;

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[REG_SEL_BIT]);

  always_comb begin
    unique case (cfg_sel)
      REG_GRID_WIDTH:  prdata = DATA_BITS'(gw_q);
      REG_GRID_HEIGHT: prdata = DATA_BITS'(gh_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    gw_ext = CMPW'(pwdata[GW_BITS-1:0]);
    if (gw_ext < CMPW'(MIN_DIM)) begin
      wsel = CMPW'(MIN_DIM - 1);
    end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
      wsel = CMPW'(MAX_WIDTH - 1);
    end else begin
      wsel = gw_ext - CMPW'(1);
    end
    wlast_new = wsel[CW-1:0];
    if (pwdata[GH_BITS-1:0] < GH_BITS'(MIN_DIM)) begin
      hlast_new = GH_BITS'(MIN_DIM - 1);
    end else begin
      hlast_new = pwdata[GH_BITS-1:0] - GH_BITS'(1);
    end
  end

  // ---------------- input side
  assign s_axis_tready = !a_valid_q || b_go;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign cur      = s_axis_tdata[SB-1:0];
  assign last_col = (col_q == wlast_q);
  assign last_row = (row_q == hlast_q);
  assign east_e   = wrap_q ? s1_q : la_rd_q;
  assign north_e  = wrap_q ? n0_q : lta_rd_q;

  assign la_raddr_w  = {1'b0, col_q} + (CW+1)'(2);
  assign lta_raddr_w = {1'b0, col_q} + (CW+1)'(1);
  assign la_raddr    = la_raddr_w[CW-1:0];
  assign lta_raddr   = lta_raddr_w[CW-1:0];

  always_comb begin
    flags.has_above = (row_q != '0);
    flags.interior  = (row_q > GH_BITS'(1)) && (col_q != '0) && !last_col;
    flags.last_row  = last_row;
    flags.last_col  = last_col;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      la_mem[col_q]  <= cur;
      lta_mem[col_q] <= above_q;
      la_rd_q        <= la_mem[la_raddr];
      lta_rd_q       <= lta_mem[lta_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_cur_q   <= cur;
      a_above_q <= above_q;
      a_north_q <= north_e;
      a_left_q  <= left_q;
      a_east_q  <= east_e;
      a_flags_q <= flags;
      above_q   <= last_col ? s0_q : east_e;
      if (col_q == '0) begin
        s0_q <= cur;
        n0_q <= above_q;
      end
      if (col_q == CW'(1)) begin
        s1_q <= cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= GW_BITS'(GW_RESET);
      gh_q    <= GH_BITS'(GH_RESET);
      wlast_q <= WLAST_RST;
      hlast_q <= HLAST_RST;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      wrap_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRID_WIDTH: begin
          gw_q    <= pwdata[GW_BITS-1:0];
          wlast_q <= wlast_new;
        end
        REG_GRID_HEIGHT: begin
          gh_q    <= pwdata[GH_BITS-1:0];
          hlast_q <= hlast_new;
        end
        default: begin
        end
      endcase
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (s_acc) begin
      wrap_q <= last_col;
      if (last_col) begin
        col_q  <= '0;
        left_q <= '0;
        row_q  <= last_row ? '0 : row_q + GH_BITS'(1);
      end else begin
        col_q  <= col_q + CW'(1);
        left_q <= above_q;
      end
    end
  end

  // ---------------- stencil datapath
  assign b_go = a_valid_q && room2;

  always_comb begin
    sum = $signed({{3{a_north_q[SB-1]}}, a_north_q})
        + $signed({{3{a_cur_q[SB-1]}}, a_cur_q})
        + $signed({{3{a_left_q[SB-1]}}, a_left_q})
        + $signed({{3{a_east_q[SB-1]}}, a_east_q})
        - $signed({a_above_q[SB-1], a_above_q, 2'b00});
    du  = sum[SB+2:2];
    val = $signed({du[SB], du}) + $signed({{2{a_above_q[SB-1]}}, a_above_q});
    if (val > $signed({{2{SMAX[SB-1]}}, SMAX})) begin
      val_sat = SMAX;
    end else if (val < $signed({{2{SMIN[SB-1]}}, SMIN})) begin
      val_sat = SMIN;
    end else begin
      val_sat = val[SB-1:0];
    end
    mag = du[SB] ? (SB+1)'(-du) : du;
    if (mag[SB:SB-1] != 2'b00) begin
      mag_sat = '1;
    end else begin
      mag_sat = mag[RB-1:0];
    end
    max_new = max_q;
    if (a_flags_q.interior && (mag_sat > max_q)) begin
      max_new = mag_sat;
    end
    r0_val = a_flags_q.interior ? val_sat : a_above_q;
    res0 = {1'b0, !a_flags_q.last_row, max_new, r0_val};
    res1 = {a_flags_q.last_col, 1'b1, max_new, a_cur_q};
    push_d0  = a_flags_q.has_above ? res0 : res1;
    push_d1  = res1;
    push     = b_go && (a_flags_q.has_above || a_flags_q.last_row);
    push_two = a_flags_q.has_above && a_flags_q.last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      max_q     <= '0;
    end else begin
      if (s_acc) begin
        a_valid_q <= 1'b1;
      end else if (b_go) begin
        a_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        max_q <= '0;
      end else if (b_go) begin
        max_q <= (a_flags_q.last_row && a_flags_q.last_col) ? '0 : max_new;
      end
    end
  end

  // ---------------- output side
  hjs_out_fifo #(
    .DW (EW)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_two_i (push_two),
    .data0_i    (push_d0),
    .data1_i    (push_d1),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (q_data)
  );

  assign m_axis_tdata = {{PADW{1'b0}}, q_data[SB+RB-1:0]};
  assign m_axis_tuser = q_data[SB+RB];
  assign m_axis_tlast = q_data[SB+RB+1];

  // ---------------- assertions
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wlast_q)
    else $error("column counter past row end");

  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= hlast_q)
    else $error("row counter past grid end");

  a_grid_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && last_row && last_col |=> (col_q == '0) && (row_q == '0))
    else $error("grid did not restart after final cell");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("grid end on a result that is not last of its item");

endmodule

>>> bench/heat_jacobi_stencil_2d_checker.sv
// Checker for the five-point Jacobi heat stencil: tracks APB register writes,
// predicts the new field from accepted cells and compares every m_axis result.
// Depends on hjs_pkg.
module heat_jacobi_stencil_2d_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [hjs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [hjs_pkg::DATA_BITS-1:0] pwdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // cell_value
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_value, residual, zero padding
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hjs_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam longint SAMPLE_MAX = 64'sd2147483647;
  localparam longint SAMPLE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] new_value;
    logic [30:0] residual;
    logic        last_of_item;
    logic        grid_done;
  } field_out_t;

  logic [GW_BITS-1:0] width_reg = GW_BITS'(GW_RESET);
  logic [GH_BITS-1:0] height_reg = GH_BITS'(GH_RESET);
  logic signed [31:0] prev_row [MAX_WIDTH];
  logic signed [31:0] prev_prev_row [MAX_WIDTH];
  logic signed [31:0] west_cell = '0;
  int unsigned row_idx = 0;
  int unsigned col_idx = 0;
  logic [30:0] peak_du = '0;
  field_out_t new_field_q[$];
  field_out_t got, want;
  int errors = 0;

  function automatic void restart_grid();
    west_cell = '0;
    row_idx = 0;
    col_idx = 0;
    peak_du = '0;
  endfunction

  task automatic jacobi_update(input logic signed [31:0] cur_val);
    int unsigned w, h;
    longint above, sum, du, val, mag;
    logic last_row, last_col;
    w = width_reg < MIN_DIM ? MIN_DIM : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < MIN_DIM ? MIN_DIM : height_reg;
    last_row = (row_idx == h - 1);
    last_col = (col_idx == w - 1);
    above = longint'(prev_row[col_idx]);
    if (row_idx >= 1) begin
      val = above;
      if (row_idx != 1 && col_idx != 0 && !last_col) begin
        sum = longint'(prev_prev_row[col_idx]) + longint'(cur_val) + longint'(west_cell)
            + longint'(prev_row[col_idx+1]) - 4 * above;
        du = sum >>> 2;
        val = above + du;
        if (val > SAMPLE_MAX) val = SAMPLE_MAX;
        if (val < SAMPLE_MIN) val = SAMPLE_MIN;
        mag = du < 0 ? -du : du;
        if (mag > SAMPLE_MAX) mag = SAMPLE_MAX;
        if (mag > longint'(peak_du)) peak_du = mag[30:0];
      end
      new_field_q.push_back('{val[31:0], peak_du, !last_row, 1'b0});
    end
    // last row: the border cell itself follows the cell above
    if (last_row) new_field_q.push_back('{cur_val, peak_du, 1'b1, last_col});
    west_cell = prev_row[col_idx];
    prev_prev_row[col_idx] = prev_row[col_idx];
    prev_row[col_idx] = cur_val;
    if (last_col) begin
      col_idx = 0;
      west_cell = '0;
      if (last_row) restart_grid();
      else row_idx = row_idx + 1;
    end else begin
      col_idx = col_idx + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = GW_BITS'(GW_RESET);
      height_reg = GH_BITS'(GH_RESET);
      restart_grid();
      new_field_q.delete();
      pending_o <= 0;
      mismatch_count_o <= errors;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[REG_SEL_BIT]))
          REG_GRID_WIDTH:  width_reg = pwdata[GW_BITS-1:0];
          REG_GRID_HEIGHT: height_reg = pwdata[GH_BITS-1:0];
          default: ;
        endcase
        restart_grid();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[62:32], m_axis_tuser, m_axis_tlast};
        if (new_field_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h/%h/%b/%b", $time,
                   got.new_value, got.residual, got.last_of_item, got.grid_done);
          errors++;
        end else begin
          want = new_field_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %h/%h/%b/%b, actual %h/%h/%b/%b",
                     $time, want.new_value, want.residual, want.last_of_item,
                     want.grid_done, got.new_value, got.residual, got.last_of_item,
                     got.grid_done);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) jacobi_update(s_axis_tdata);
      pending_o <= new_field_q.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

>>> bench/heat_jacobi_stencil_2d_top_tb.sv
// Stimulus and verdict for heat_jacobi_stencil_2d_top: directed and random grids,
// several width/height settings written over APB, random stalls on both streams.
// Depends on hjs_pkg, heat_jacobi_stencil_2d_top and heat_jacobi_stencil_2d_checker.
module heat_jacobi_stencil_2d_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hjs_pkg::*;

  localparam int N_PHASES = 18;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WIDTH = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;
  int mismatch_count;
  int pending;
  // 0: sender idles 36%, receiver 59%; 1: the reverse; 2: no idling
  int idle_mode = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  heat_jacobi_stencil_2d_top uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  heat_jacobi_stencil_2d_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  always @(posedge clk_i)
    m_axis_tready <= (idle_mode == 2) || ($urandom_range(99) >= (idle_mode == 0 ? 59 : 36));

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
          !rst_ni)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_cell(input logic [31:0] v);
    while (idle_mode != 2 && $urandom_range(99) < (idle_mode == 0 ? 36 : 59)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_cells(input int n);
    logic [31:0] level, v;
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) level = $urandom();
      case ($urandom_range(15))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2, 3: v = $urandom();
        4: v = level;
        default: v = level + $urandom_range(1 << 18) - (1 << 17);
      endcase
      send_cell(v);
    end
  endtask

  // wait until every transaction in flight has left the block
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [GW_BITS-1:0] w, input logic [GH_BITS-1:0] h);
    logic [31:0] word;
    word = $urandom();
    word[GW_BITS-1:0] = w;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_GRID_WIDTH, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    word = $urandom();
    word[GH_BITS-1:0] = h;
    penable <= 1'b0;
    paddr <= {REG_GRID_HEIGHT, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] v;
    logic [GW_BITS-1:0] w;
    logic [GH_BITS-1:0] h;
    int ew, eh, cells;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_grid(3, 3);
    // saturating change both ways, then a negative sum that is not a multiple of four
    for (int g = 0; g < 3; g++) begin
      for (int k = 0; k < 9; k++) begin
        if (g == 0) v = (k == 4) ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (g == 1) v = (k == 4) ? 32'h7fff_ffff : 32'h8000_0000;
        else v = (k == 1) ? 32'hffff_ffff : 32'h0;
        send_cell(v);
      end
    end
    for (int p = 0; p < N_PHASES; p++) begin
      idle_mode = p * 3 / N_PHASES;
      wait_idle();
      case (p)
        5: begin w = GW_BITS'($urandom_range(3, 12)); h = 2; end
        9: begin w = 2047; h = 65535; end
        12: begin w = 0; h = 1; end
        15: begin w = 2; h = 0; end
        default: begin
          w = ($urandom_range(99) < 80) ? GW_BITS'($urandom_range(3, 10))
                                        : GW_BITS'($urandom_range(11, 24));
          h = ($urandom_range(9) == 0) ? GH_BITS'($urandom_range(0, 2))
                                       : GH_BITS'($urandom_range(3, 6));
        end
      endcase
      set_grid(w, h);
      ew = w < MIN_DIM ? MIN_DIM : (w > MAX_WIDTH ? MAX_WIDTH : w);
      eh = h < MIN_DIM ? MIN_DIM : h;
      if (p == 5) begin
        cells = ew * eh;
      end else if (p == 9) begin
        cells = ew + $urandom_range(3, 40);
      end else begin
        cells = ew * eh;
        if ($urandom_range(1) == 1) cells += $urandom_range(1, ew * eh - 1);
      end
      send_cells(cells);
    end
    wait_idle();
    if (mismatch_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
